>>> hdl/stq_pkg.sv
// Shared types and constants for the sorted timeout queue.
package stq_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam int CMD_W   = 2;
  localparam int OWNER_W = 16;
  localparam int TID_W   = 32;
  localparam int DELAY_W = 32;
  localparam int TIME_W  = 64;
  localparam int EV_W    = 3;
  localparam int RMC_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_CANCEL   = 2'd2
  } cmd_t;

  typedef enum logic [EV_W-1:0] {
    EV_EXPIRED    = 3'd0,
    EV_REGISTERED = 3'd1,
    EV_REJECTED   = 3'd2,
    EV_CANCELLED  = 3'd3,
    EV_NONE_DUE   = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_TICK,
    ST_CANC
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  deadline;
    logic [OWNER_W-1:0] owner;
    logic [TID_W-1:0]   timer_tag;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t           op;
    logic               match_owner;
    logic               wrapped;
    logic [TIME_W-1:0]  key_time;
    logic [OWNER_W-1:0] key_owner;
    logic [TID_W-1:0]   new_timer;
  } cell_ctrl_t;

  // rippled from cell to cell, head towards tail
  typedef struct packed {
    logic               ge;
    logic               seen1;
    logic               seen2;
    logic [OWNER_W-1:0] sel_owner;
    logic [TID_W-1:0]   sel_timer;
  } link_t;

endpackage

>>> hdl/stq_cell.sv
// One slot of the sorted chain: holds an entry, shifts for insert and compaction.
module stq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_pkg::cell_ctrl_t ctrl_i,
  input  stq_pkg::link_t     link_i,
  output stq_pkg::link_t     link_o,
  input  stq_pkg::entry_t    left_i,
  input  stq_pkg::entry_t    right_i,
  output stq_pkg::entry_t    ent_o
);

  stq_pkg::entry_t ent_r;
  stq_pkg::entry_t ent_nxt;
  logic            ge_w;
  logic            due_w;
  logic            hit_w;

  // new deadline goes in front of this slot only if the slot is empty or its deadline is strictly later
  assign ge_w  = !ent_r.valid || (ent_r.deadline > ctrl_i.key_time);
  assign due_w = ctrl_i.wrapped ? (ent_r.deadline >= ctrl_i.key_time)
                                : (ent_r.deadline <= ctrl_i.key_time);
  assign hit_w = ent_r.valid &&
                 (ctrl_i.match_owner ? (ent_r.owner == ctrl_i.key_owner) : due_w);

  always_comb begin
    link_o.ge    = ge_w;
    link_o.seen1 = link_i.seen1 | hit_w;
    link_o.seen2 = link_i.seen2 | (link_i.seen1 & hit_w);
    if (hit_w && !link_i.seen1) begin
      link_o.sel_owner = ent_r.owner;
      link_o.sel_timer = ent_r.timer_tag;
    end else begin
      link_o.sel_owner = link_i.sel_owner;
      link_o.sel_timer = link_i.sel_timer;
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    case (ctrl_i.op)
      stq_pkg::CELL_INSERT: begin
        if (link_i.ge) begin
          ent_nxt = left_i;
        end else if (ge_w) begin
          ent_nxt.valid     = 1'b1;
          ent_nxt.deadline  = ctrl_i.key_time;
          ent_nxt.owner     = ctrl_i.key_owner;
          ent_nxt.timer_tag = ctrl_i.new_timer;
        end
      end
      stq_pkg::CELL_REMOVE: begin
        // first hit and everything behind it moves up one slot
        if (link_i.seen1 || hit_w) begin
          ent_nxt = right_i;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;

endmodule

>>> hdl/sorted_timeout_queue_top.sv
// Top level of the sorted timeout queue: controller, chain of cells, result register.
// Pending timeouts sit in a chain of stq_pkg::DEPTH cells in ascending deadline
// order, equal deadlines in arrival order. A register command first adds the delay
// to the time, then inserts into the chain and gives one beat: registered, or
// rejected when full. A tick first latches the new time, then removes the expired
// entries, each giving one beat in table order (at most stq_pkg::MAX_RESULTS per
// tick), or gives a single nothing-due beat. A cancel removes every entry of the
// owner, then gives its single summary beat with the removed count. The chain
// compacts out one entry per cycle, in a tick only while the output is free. A
// finished beat waits in the output register while out_stall is high; input is
// stalled while an item is in progress. Command code 3 is accepted and ignored.
module sorted_timeout_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_owner_id,
  input  logic [31:0] in_timer_tag,
  input  logic [31:0] in_delay,
  input  logic [63:0] in_time_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_owner_id_out,
  output logic [31:0] out_timer_tag_out,
  output logic [4:0]  out_removed_count,
  output logic        out_last
);

  stq_pkg::state_t                 state_r, state_nxt;
  logic [stq_pkg::TIME_W-1:0]      key_time_r, key_time_nxt;
  logic [stq_pkg::OWNER_W-1:0]     key_owner_r, key_owner_nxt;
  logic [stq_pkg::TID_W-1:0]       new_timer_r, new_timer_nxt;
  logic                            wrapped_r, wrapped_nxt;
  logic [stq_pkg::TIME_W-1:0]      last_time_r, last_time_nxt;
  logic [stq_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [stq_pkg::NRES_W-1:0]      nres_r, nres_nxt;
  logic [stq_pkg::CNT_W-1:0]       rm_cnt_r, rm_cnt_nxt;

  logic                            out_valid_r, out_valid_nxt;
  stq_pkg::ev_t                    out_ev_r, out_ev_nxt;
  logic [stq_pkg::OWNER_W-1:0]     out_own_r, out_own_nxt;
  logic [stq_pkg::TID_W-1:0]       out_tid_r, out_tid_nxt;
  logic [stq_pkg::RMC_W-1:0]       out_rm_r, out_rm_nxt;
  logic                            out_last_r, out_last_nxt;

  stq_pkg::cell_ctrl_t             ctrl_w;
  stq_pkg::cell_op_t               op_w;
  stq_pkg::link_t                  link_w [0:stq_pkg::DEPTH];
  stq_pkg::entry_t                 ent_w  [0:stq_pkg::DEPTH+1];
  logic [stq_pkg::DEPTH-1:0]       vld_w;
  logic                            accept_w;
  logic                            out_free_w;
  logic                            hit_any_w;
  logic                            more_w;
  logic                            final_w;

  assign in_stall   = (state_r != stq_pkg::ST_IDLE);
  assign accept_w   = in_valid && !in_stall;
  assign out_free_w = !out_valid_r || !out_stall;

  assign ctrl_w.op          = op_w;
  assign ctrl_w.match_owner = (state_r == stq_pkg::ST_CANC);
  assign ctrl_w.wrapped     = wrapped_r;
  assign ctrl_w.key_time    = key_time_r;
  assign ctrl_w.key_owner   = key_owner_r;
  assign ctrl_w.new_timer   = new_timer_r;

  assign link_w[0]                = '0;
  assign ent_w[0]                 = '0;
  assign ent_w[stq_pkg::DEPTH+1]  = '0;

  for (genvar i = 0; i < stq_pkg::DEPTH; i++) begin : g_cell
    stq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl_i  (ctrl_w),
      .link_i  (link_w[i]),
      .link_o  (link_w[i+1]),
      .left_i  (ent_w[i]),
      .right_i (ent_w[i+2]),
      .ent_o   (ent_w[i+1])
    );
    assign vld_w[i] = ent_w[i+1].valid;
  end

  assign hit_any_w = link_w[stq_pkg::DEPTH].seen1;
  assign more_w    = link_w[stq_pkg::DEPTH].seen2;
  assign final_w   = !more_w ||
                     (nres_r == stq_pkg::NRES_W'(stq_pkg::MAX_RESULTS - 1));

  always_comb begin
    state_nxt     = state_r;
    key_time_nxt  = key_time_r;
    key_owner_nxt = key_owner_r;
    new_timer_nxt = new_timer_r;
    wrapped_nxt   = wrapped_r;
    last_time_nxt = last_time_r;
    cnt_nxt       = cnt_r;
    nres_nxt      = nres_r;
    rm_cnt_nxt    = rm_cnt_r;
    op_w          = stq_pkg::CELL_HOLD;
    out_valid_nxt = out_valid_r && out_stall;
    out_ev_nxt    = out_ev_r;
    out_own_nxt   = out_own_r;
    out_tid_nxt   = out_tid_r;
    out_rm_nxt    = out_rm_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      stq_pkg::ST_IDLE: begin
        if (accept_w) begin
          case (in_command)
            stq_pkg::CMD_REGISTER: begin
              key_time_nxt  = in_time_value + stq_pkg::TIME_W'(in_delay);
              key_owner_nxt = in_owner_id;
              new_timer_nxt = in_timer_tag;
              state_nxt     = stq_pkg::ST_INS;
            end
            stq_pkg::CMD_TICK: begin
              // wrapped: entries at or after the old time are due
              wrapped_nxt   = (in_time_value < last_time_r);
              key_time_nxt  = (in_time_value < last_time_r) ? last_time_r : in_time_value;
              last_time_nxt = in_time_value;
              nres_nxt      = '0;
              state_nxt     = stq_pkg::ST_TICK;
            end
            stq_pkg::CMD_CANCEL: begin
              key_owner_nxt = in_owner_id;
              rm_cnt_nxt    = '0;
              state_nxt     = stq_pkg::ST_CANC;
            end
            default: state_nxt = stq_pkg::ST_IDLE;
          endcase
        end
      end
      stq_pkg::ST_INS: begin
        if (out_free_w) begin
          if (cnt_r == stq_pkg::CNT_W'(stq_pkg::DEPTH)) begin
            out_ev_nxt = stq_pkg::EV_REJECTED;
          end else begin
            op_w       = stq_pkg::CELL_INSERT;
            cnt_nxt    = cnt_r + stq_pkg::CNT_W'(1);
            out_ev_nxt = stq_pkg::EV_REGISTERED;
          end
          out_valid_nxt = 1'b1;
          out_own_nxt   = '0;
          out_tid_nxt   = '0;
          out_rm_nxt    = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = stq_pkg::ST_IDLE;
        end
      end
      stq_pkg::ST_TICK: begin
        if (out_free_w) begin
          out_valid_nxt = 1'b1;
          out_rm_nxt    = '0;
          if (hit_any_w) begin
            op_w         = stq_pkg::CELL_REMOVE;
            cnt_nxt      = cnt_r - stq_pkg::CNT_W'(1);
            nres_nxt     = nres_r + stq_pkg::NRES_W'(1);
            out_ev_nxt   = stq_pkg::EV_EXPIRED;
            out_own_nxt  = link_w[stq_pkg::DEPTH].sel_owner;
            out_tid_nxt  = link_w[stq_pkg::DEPTH].sel_timer;
            out_last_nxt = final_w;
            if (final_w) begin
              state_nxt = stq_pkg::ST_IDLE;
            end
          end else begin
            out_ev_nxt   = stq_pkg::EV_NONE_DUE;
            out_own_nxt  = '0;
            out_tid_nxt  = '0;
            out_last_nxt = 1'b1;
            state_nxt    = stq_pkg::ST_IDLE;
          end
        end
      end
      stq_pkg::ST_CANC: begin
        if (hit_any_w) begin
          op_w       = stq_pkg::CELL_REMOVE;
          cnt_nxt    = cnt_r - stq_pkg::CNT_W'(1);
          rm_cnt_nxt = rm_cnt_r + stq_pkg::CNT_W'(1);
        end else if (out_free_w) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = stq_pkg::EV_CANCELLED;
          out_own_nxt   = '0;
          out_tid_nxt   = '0;
          out_rm_nxt    = stq_pkg::RMC_W'(rm_cnt_r);
          out_last_nxt  = 1'b1;
          state_nxt     = stq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stq_pkg::ST_IDLE;
      cnt_r       <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_time_r <= last_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_time_r  <= key_time_nxt;
    key_owner_r <= key_owner_nxt;
    new_timer_r <= new_timer_nxt;
    wrapped_r   <= wrapped_nxt;
    nres_r      <= nres_nxt;
    rm_cnt_r    <= rm_cnt_nxt;
    out_ev_r    <= out_ev_nxt;
    out_own_r   <= out_own_nxt;
    out_tid_r   <= out_tid_nxt;
    out_rm_r    <= out_rm_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_ev_r;
  assign out_owner_id_out  = out_own_r;
  assign out_timer_tag_out = out_tid_r;
  assign out_removed_count = out_rm_r;
  assign out_last          = out_last_r;

`ifndef ASSERT_OFF
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_w) == cnt_r)
    else $error("entry count disagrees with occupied cells");

  a_packed_head: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_w + stq_pkg::DEPTH'(1)) & vld_w) == '0)
    else $error("occupied cells not packed from the head");

  a_mid_tick_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == stq_pkg::ST_TICK))
    else $error("non-final beat outside a tick");
`endif

endmodule
